// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the record table RTL.
// Depends on clk and rst being visible at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond implies prop in the same cycle.
`define AST_SAME(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Check that cond implies prop in the next cycle.
`define AST_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== hdl/rss_pkg.sv =====
// Types and constants for the name record sort and search block.
// No dependencies; used by rss_mem, rss_cmp and the top level.
package rss_pkg;

  localparam int SUR_HI_W   = 64;
  localparam int SUR_LO_W   = 56;
  localparam int FIRST_HI_W = 64;
  localparam int FIRST_LO_W = 16;
  localparam int SALARY_W   = 32;
  localparam int REC_W      = SUR_HI_W + SUR_LO_W + FIRST_HI_W + FIRST_LO_W + SALARY_W;
  localparam int SUR_W      = SUR_HI_W + SUR_LO_W;
  localparam int FIRST_W    = FIRST_HI_W + FIRST_LO_W;
  localparam int KEY_W      = SUR_W + FIRST_W;

  // surname_hi sits in the lowest bits
  typedef struct packed {
    logic [SALARY_W-1:0]   salary;
    logic [FIRST_LO_W-1:0] first_lo;
    logic [FIRST_HI_W-1:0] first_hi;
    logic [SUR_LO_W-1:0]   surname_lo;
    logic [SUR_HI_W-1:0]   surname_hi;
  } rec_t;

  typedef enum logic [1:0] {
    REQ_LOAD       = 2'd0,
    REQ_SORT       = 2'd1,
    REQ_FIND_SUR   = 2'd2,
    REQ_FIND_FIRST = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_REC,
    OUT_MEM
  } out_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MISS,
    ST_SORT_FETCH,
    ST_SORT_KEY,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_EMIT_RD,
    ST_EMIT,
    ST_FIND_RD,
    ST_FIND_CMP
  } state_t;

  typedef struct packed {
    logic gt;
    logic sur_eq;
    logic first_eq;
  } cmp_res_t;

  function automatic logic [SUR_W-1:0] rec_sur(rec_t r);
    return {r.surname_hi, r.surname_lo};
  endfunction

  function automatic logic [FIRST_W-1:0] rec_first(rec_t r);
    return {r.first_hi, r.first_lo};
  endfunction

endpackage

// ===== hdl/rss_mem.sv =====
// Record table storage: one write port, one registered read port.
// Depends on rss_pkg for the record type.
module rss_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rss_pkg::rec_t   wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output rss_pkg::rec_t   rd_data
);

  rss_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/rss_cmp.sv =====
// Shared key comparator: ordering on surname then first name, and name equality.
// Depends on rss_pkg for the record and result types.
module rss_cmp (
  input  rss_pkg::rec_t    a,
  input  rss_pkg::rec_t    b,
  output rss_pkg::cmp_res_t res
);

  logic [rss_pkg::KEY_W-1:0] key_a;
  logic [rss_pkg::KEY_W-1:0] key_b;

  assign key_a = {rss_pkg::rec_sur(a), rss_pkg::rec_first(a)};
  assign key_b = {rss_pkg::rec_sur(b), rss_pkg::rec_first(b)};

  always_comb begin
    res.gt       = key_a > key_b;
    res.sur_eq   = rss_pkg::rec_sur(a) == rss_pkg::rec_sur(b);
    res.first_eq = rss_pkg::rec_first(a) == rss_pkg::rec_first(b);
  end

endmodule

// ===== hdl/name_record_sort_and_search.sv =====
// Name record table with stable in-place insertion sort and linear search.
// A find reads one record at a time through the single table read port and comparator.
// A sort runs insertion passes on that same port and comparator: per record it fetches
// the record as the key, then compares it with the earlier records, shifting each larger
// one up one position until the key is placed; it then emits each record in table order.
// Input is not accepted until the request is done and its last result has entered the
// output register. The table needs no clearing after reset.
`include "assert_macros.svh"

module name_record_sort_and_search #(
  parameter int NUM_ENTRIES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // surname_hi[63:0], surname_lo[119:64], first_hi[183:120], first_lo[199:184],
  // salary[231:200]
  input  logic [rss_pkg::REC_W-1:0] s_axis_tdata,
  // req_type[1:0]
  input  logic [1:0]                s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // out_surname_hi[63:0], out_surname_lo[119:64], out_first_hi[183:120],
  // out_first_lo[199:184], out_salary[231:200]
  output logic [rss_pkg::REC_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]                m_axis_tuser,
  // last_of_run
  output logic                      m_axis_tlast
);

  localparam int AW = $clog2(NUM_ENTRIES);
  localparam int CW = $clog2(NUM_ENTRIES + 1);

  rss_pkg::state_t   state;
  rss_pkg::state_t   state_next;
  rss_pkg::req_t     req;
  rss_pkg::rec_t     rec;
  rss_pkg::rec_t     rd_data;
  rss_pkg::rec_t     mem_wdata;
  rss_pkg::cmp_res_t cmp;
  rss_pkg::out_sel_t out_sel;
  rss_pkg::status_t  out_status;

  logic [CW-1:0] cnt;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic [CW-1:0] jm1;
  logic [CW-1:0] jm2;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic          mem_re;
  logic          out_load;
  logic          out_last;
  logic          slot_free;
  logic          accept;
  logic          hit;
  logic          i_last;

  assign jm1       = j - CW'(1);
  assign jm2       = j - CW'(2);
  assign slot_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == rss_pkg::ST_IDLE);
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign hit       = (req == rss_pkg::REQ_FIND_SUR) ? cmp.sur_eq : cmp.first_eq;
  assign i_last    = (i + CW'(1)) == cnt;

  rss_mem #(
    .DEPTH (NUM_ENTRIES)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (rd_data)
  );

  rss_cmp u_cmp (
    .a   (rd_data),
    .b   (rec),
    .res (cmp)
  );

  always_comb begin
    state_next = state;
    case (state)
      rss_pkg::ST_IDLE: begin
        if (accept) begin
          case (rss_pkg::req_t'(s_axis_tuser))
            rss_pkg::REQ_LOAD: begin
              state_next = (cnt == CW'(NUM_ENTRIES)) ? rss_pkg::ST_MISS : rss_pkg::ST_LOAD;
            end
            rss_pkg::REQ_SORT: begin
              state_next = (cnt == '0) ? rss_pkg::ST_MISS : rss_pkg::ST_SORT_FETCH;
            end
            default: begin
              state_next = (cnt == '0) ? rss_pkg::ST_MISS : rss_pkg::ST_FIND_RD;
            end
          endcase
        end
      end
      rss_pkg::ST_LOAD, rss_pkg::ST_MISS: begin
        if (slot_free) state_next = rss_pkg::ST_IDLE;
      end
      rss_pkg::ST_SORT_FETCH: begin
        state_next = (i == cnt) ? rss_pkg::ST_EMIT_RD : rss_pkg::ST_SORT_KEY;
      end
      rss_pkg::ST_SORT_KEY: state_next = rss_pkg::ST_SORT_CMP;
      rss_pkg::ST_SORT_CMP: begin
        if (cmp.gt) begin
          state_next = (jm1 == '0) ? rss_pkg::ST_SORT_PLACE : rss_pkg::ST_SORT_CMP;
        end else begin
          state_next = rss_pkg::ST_SORT_FETCH;
        end
      end
      rss_pkg::ST_SORT_PLACE: state_next = rss_pkg::ST_SORT_FETCH;
      rss_pkg::ST_EMIT_RD:    state_next = rss_pkg::ST_EMIT;
      rss_pkg::ST_EMIT: begin
        if (slot_free) state_next = i_last ? rss_pkg::ST_IDLE : rss_pkg::ST_EMIT_RD;
      end
      rss_pkg::ST_FIND_RD: state_next = rss_pkg::ST_FIND_CMP;
      rss_pkg::ST_FIND_CMP: begin
        if (hit) begin
          if (slot_free) state_next = rss_pkg::ST_IDLE;
        end else begin
          state_next = i_last ? rss_pkg::ST_MISS : rss_pkg::ST_FIND_RD;
        end
      end
      default: state_next = rss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = j[AW-1:0];
    mem_wdata  = rec;
    mem_re     = 1'b0;
    mem_raddr  = i[AW-1:0];
    out_load   = 1'b0;
    out_sel    = rss_pkg::OUT_ZERO;
    out_status = rss_pkg::STAT_OK;
    out_last   = 1'b1;
    case (state)
      rss_pkg::ST_LOAD: begin
        if (slot_free) begin
          mem_we    = 1'b1;
          mem_waddr = cnt[AW-1:0];
          out_load  = 1'b1;
          out_sel   = rss_pkg::OUT_REC;
        end
      end
      rss_pkg::ST_MISS: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_status = (req == rss_pkg::REQ_LOAD) ? rss_pkg::STAT_FULL : rss_pkg::STAT_NONE;
        end
      end
      rss_pkg::ST_SORT_FETCH: mem_re = (i != cnt);
      rss_pkg::ST_SORT_KEY: begin
        mem_re    = 1'b1;
        mem_raddr = jm1[AW-1:0];
      end
      rss_pkg::ST_SORT_CMP: begin
        mem_we = 1'b1;
        if (cmp.gt) begin
          mem_wdata = rd_data;
          mem_re    = (jm1 != '0);
          mem_raddr = jm2[AW-1:0];
        end
      end
      rss_pkg::ST_SORT_PLACE: mem_we = 1'b1;
      rss_pkg::ST_EMIT_RD:    mem_re = 1'b1;
      rss_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_load = 1'b1;
          out_sel  = rss_pkg::OUT_MEM;
          out_last = i_last;
        end
      end
      rss_pkg::ST_FIND_RD: mem_re = 1'b1;
      rss_pkg::ST_FIND_CMP: begin
        if (hit && slot_free) begin
          out_load = 1'b1;
          out_sel  = rss_pkg::OUT_MEM;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rss_pkg::ST_IDLE;
      cnt   <= '0;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      case (state)
        rss_pkg::ST_IDLE: begin
          if (accept) begin
            i <= (rss_pkg::req_t'(s_axis_tuser) == rss_pkg::REQ_SORT) ? CW'(1) : '0;
          end
        end
        rss_pkg::ST_LOAD: begin
          if (slot_free) cnt <= cnt + CW'(1);
        end
        rss_pkg::ST_SORT_FETCH: begin
          if (i == cnt) begin
            i <= '0;
          end else begin
            j <= i;
          end
        end
        rss_pkg::ST_SORT_CMP: begin
          if (cmp.gt) begin
            j <= jm1;
          end else begin
            i <= i + CW'(1);
          end
        end
        rss_pkg::ST_SORT_PLACE: i <= i + CW'(1);
        rss_pkg::ST_EMIT: begin
          if (slot_free) i <= i + CW'(1);
        end
        rss_pkg::ST_FIND_CMP: begin
          if (!hit) i <= i + CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  // hold request and record; the sort key reuses the record register
  always_ff @(posedge clk) begin
    if (accept) begin
      req <= rss_pkg::req_t'(s_axis_tuser);
      rec <= rss_pkg::rec_t'(s_axis_tdata);
    end else if (state == rss_pkg::ST_SORT_KEY) begin
      rec <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tuser <= out_status;
      m_axis_tlast <= out_last;
      case (out_sel)
        rss_pkg::OUT_REC: m_axis_tdata <= rec;
        rss_pkg::OUT_MEM: m_axis_tdata <= rd_data;
        default:          m_axis_tdata <= '0;
      endcase
    end
  end

  `AST_SAME(a_ready_idle, s_axis_tready, state == rss_pkg::ST_IDLE, "ready outside idle")
  `AST_SAME(a_no_overwrite, out_load, !m_axis_tvalid || m_axis_tready, "output overwritten")
  `AST_SAME(a_cnt_range, 1'b1, cnt <= CW'(NUM_ENTRIES), "record count out of range")
  `AST_NEXT(a_load_count, state == rss_pkg::ST_LOAD && out_load, cnt == $past(cnt) + CW'(1), "load count not advanced")

endmodule

// ===== tb/tb_name_record_sort_and_search.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for name_record_sort_and_search: directed rows, then random
// loads, sorts and finds, each reply checked against a roster predictor. Uses rss_pkg.
module tb_name_record_sort_and_search;

  localparam int NUM_ENTRIES = 16;
  localparam int RANDOM_PER_PHASE = 70;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    rss_pkg::status_t status;
    rss_pkg::rec_t    rec;
    logic             last;
  } reply_t;

  typedef struct {
    rss_pkg::req_t    req;
    rss_pkg::rec_t    data;
    bit               typed;
    rss_pkg::status_t status;
    rss_pkg::rec_t    rec;
  } row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_axis_tvalid = 1'b0;
  logic                      s_axis_tready;
  logic [rss_pkg::REC_W-1:0] s_axis_tdata = '0;
  logic [1:0]                s_axis_tuser = '0;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready = 1'b0;
  logic [rss_pkg::REC_W-1:0] m_axis_tdata;
  logic [1:0]                m_axis_tuser;
  logic                      m_axis_tlast;

  rss_pkg::rec_t roster [NUM_ENTRIES];
  int            roster_count = 0;
  reply_t        expected_replies [$];
  row_t          directed_rows [$];
  int            fail_count = 0;
  int            gap_pct = 0;
  int            stall_pct = 0;
  bit            hold_request = 1'b0;
  int            holdoff_left = 0;
  int            cycle_count = 0;

  name_record_sort_and_search #(
    .NUM_ENTRIES(NUM_ENTRIES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always #1 clk = ~clk;

  function automatic logic [rss_pkg::KEY_W-1:0] sort_key(rss_pkg::rec_t r);
    return {r.surname_hi, r.surname_lo, r.first_hi, r.first_lo};
  endfunction

  function automatic logic [119:0] pack_name(string s, int len);
    logic [119:0] v;
    v = '0;
    for (int k = 0; k < s.len() && k < len; k++) v[8*(len-1-k) +: 8] = s[k];
    return v;
  endfunction

  function automatic logic [119:0] random_name(int len);
    logic [119:0] v;
    int n;
    int alpha;
    v = '0;
    n = $urandom_range(len, 1);
    alpha = $urandom_range(1) ? 3 : 26;
    for (int k = 0; k < n; k++) v[8*(len-1-k) +: 8] = 8'h41 + 8'($urandom_range(alpha - 1));
    return v;
  endfunction

  function automatic rss_pkg::rec_t make_rec(logic [119:0] sur, logic [79:0] first,
                                             logic [31:0] sal);
    rss_pkg::rec_t r;
    r.surname_hi = sur[119:56];
    r.surname_lo = sur[55:0];
    r.first_hi   = first[79:16];
    r.first_lo   = first[15:0];
    r.salary     = sal;
    return r;
  endfunction

  function automatic rss_pkg::rec_t random_bits();
    logic [255:0] v;
    for (int k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
    return rss_pkg::rec_t'(v[rss_pkg::REC_W-1:0]);
  endfunction

  task automatic predict_roster_reply(input rss_pkg::req_t req, input rss_pkg::rec_t d);
    rss_pkg::rec_t swap;
    int            j;
    bit            hit;
    case (req)
      rss_pkg::REQ_LOAD: begin
        if (roster_count >= NUM_ENTRIES) begin
          expected_replies.push_back('{rss_pkg::STAT_FULL, '0, 1'b1});
        end else begin
          roster[roster_count] = d;
          roster_count++;
          expected_replies.push_back('{rss_pkg::STAT_OK, d, 1'b1});
        end
      end
      rss_pkg::REQ_SORT: begin
        if (roster_count == 0) begin
          expected_replies.push_back('{rss_pkg::STAT_NONE, '0, 1'b1});
        end else begin
          for (int i = 1; i < roster_count; i++) begin
            j = i;
            while (j > 0 && sort_key(roster[j-1]) > sort_key(roster[j])) begin
              swap = roster[j-1];
              roster[j-1] = roster[j];
              roster[j] = swap;
              j--;
            end
          end
          for (int i = 0; i < roster_count; i++)
            expected_replies.push_back('{rss_pkg::STAT_OK, roster[i],
                                         (i == roster_count - 1)});
        end
      end
      default: begin
        for (int i = 0; i < roster_count; i++) begin
          if (req == rss_pkg::REQ_FIND_SUR)
            hit = {roster[i].surname_hi, roster[i].surname_lo} == {d.surname_hi, d.surname_lo};
          else
            hit = {roster[i].first_hi, roster[i].first_lo} == {d.first_hi, d.first_lo};
          if (hit) begin
            expected_replies.push_back('{rss_pkg::STAT_OK, roster[i], 1'b1});
            return;
          end
        end
        expected_replies.push_back('{rss_pkg::STAT_NONE, '0, 1'b1});
      end
    endcase
  endtask

  task automatic send_request(input rss_pkg::req_t req, input rss_pkg::rec_t d);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= d;
    do @(posedge clk); while (!s_axis_tready);
    predict_roster_reply(req, d);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  task automatic random_request();
    rss_pkg::req_t req;
    rss_pkg::rec_t d;
    int            roll;
    int            pick;
    logic [119:0]  sur;
    logic [79:0]   first;
    roll = $urandom_range(99);
    if (roster_count < NUM_ENTRIES)
      req = roll < 45 ? rss_pkg::REQ_LOAD : roll < 60 ? rss_pkg::REQ_SORT :
            roll < 80 ? rss_pkg::REQ_FIND_SUR : rss_pkg::REQ_FIND_FIRST;
    else
      req = roll < 8 ? rss_pkg::REQ_LOAD : roll < 30 ? rss_pkg::REQ_SORT :
            roll < 65 ? rss_pkg::REQ_FIND_SUR : rss_pkg::REQ_FIND_FIRST;
    d = random_bits();
    if (req != rss_pkg::REQ_SORT && $urandom_range(9) != 0) begin
      sur = random_name(15);
      first = 80'(random_name(10));
      if (roster_count > 0 && $urandom_range(1)) begin
        pick = $urandom_range(roster_count - 1);
        sur = {roster[pick].surname_hi, roster[pick].surname_lo};
      end
      if (roster_count > 0 && $urandom_range(1)) begin
        pick = $urandom_range(roster_count - 1);
        first = {roster[pick].first_hi, roster[pick].first_lo};
      end
      if ($urandom_range(9) == 0) sur[7:0] = sur[7:0] ^ 8'h01;
      if ($urandom_range(9) == 0) first[7:0] = first[7:0] ^ 8'h01;
      case ($urandom_range(9))
        0: d.salary = 32'h8000_0000;
        1: d.salary = 32'h7fff_ffff;
        default: ;
      endcase
      d = make_rec(sur, first, d.salary);
    end
    send_request(req, d);
  endtask

  task automatic add_row(input rss_pkg::req_t req, input rss_pkg::rec_t data, input bit typed,
                         input rss_pkg::status_t status, input rss_pkg::rec_t rec);
    directed_rows.push_back('{req, data, typed, status, rec});
  endtask

  task automatic check_reply();
    reply_t        want;
    rss_pkg::rec_t got;
    got = rss_pkg::rec_t'(m_axis_tdata);
    if (expected_replies.size() == 0) begin
      $error("unexpected transaction: status %0d surname_hi %h", m_axis_tuser, got.surname_hi);
      fail_count++;
      return;
    end
    want = expected_replies.pop_front();
    if (m_axis_tuser !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
      fail_count++;
    end
    if (got.surname_hi !== want.rec.surname_hi) begin
      $error("surname_hi: expected %h, got %h", want.rec.surname_hi, got.surname_hi);
      fail_count++;
    end
    if (got.surname_lo !== want.rec.surname_lo) begin
      $error("surname_lo: expected %h, got %h", want.rec.surname_lo, got.surname_lo);
      fail_count++;
    end
    if (got.first_hi !== want.rec.first_hi) begin
      $error("first_hi: expected %h, got %h", want.rec.first_hi, got.first_hi);
      fail_count++;
    end
    if (got.first_lo !== want.rec.first_lo) begin
      $error("first_lo: expected %h, got %h", want.rec.first_lo, got.first_lo);
      fail_count++;
    end
    if (got.salary !== want.rec.salary) begin
      $error("salary: expected %0d, got %0d", $signed(want.rec.salary), $signed(got.salary));
      fail_count++;
    end
    if (m_axis_tlast !== want.last) begin
      $error("last_of_run: expected %0d, got %0d", want.last, m_axis_tlast);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (hold_request) begin
        holdoff_left = HOLDOFF_CYCLES;
        hold_request = 1'b0;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("name_record_sort_and_search: mismatch");
      $finish;
    end
  end

  initial begin
    rss_pkg::rec_t zero_rec;
    rss_pkg::rec_t ones_rec;
    rss_pkg::rec_t john_max;
    rss_pkg::rec_t anna_min;
    rss_pkg::rec_t john_dup;
    rss_pkg::rec_t past_nul;
    rss_pkg::rec_t full_len;
    rss_pkg::rec_t high_byte;
    rss_pkg::rec_t near_miss;
    int            gap_tab [4];
    int            stall_tab [4];

    zero_rec  = '0;
    ones_rec  = '1;
    john_max  = make_rec(pack_name("SMITH", 15), 80'(pack_name("JOHN", 10)), 32'h7fff_ffff);
    anna_min  = make_rec(pack_name("SMITH", 15), 80'(pack_name("ANNA", 10)), 32'h8000_0000);
    john_dup  = make_rec(pack_name("SMITH", 15), 80'(pack_name("JOHN", 10)), 32'd1234);
    past_nul  = make_rec(pack_name("SMITH", 15) | (120'h58 << 64),
                         80'(pack_name("JOHN", 10)) | (80'h59 << 32), 32'd77);
    full_len  = make_rec(pack_name("ABCDEFGHIJKLMNO", 15), 80'(pack_name("PQRSTUVWXY", 10)),
                         32'hffff_fffb);
    high_byte = make_rec({8'h80, 8'h41, 104'h0}, 80'(pack_name("B", 10)), 32'd5);
    near_miss = make_rec(pack_name("SMIT", 15),
                         80'(pack_name("JOHN", 10)) | (80'h5a << 32), 32'd0);
    gap_tab   = '{0, 47, 0, 14};
    stall_tab = '{0, 0, 47, 14};

    // empty table, then extremes and duplicate keys, then finds and sorts
    add_row(rss_pkg::REQ_SORT,       ones_rec,  1, rss_pkg::STAT_NONE, zero_rec);
    add_row(rss_pkg::REQ_FIND_SUR,   ones_rec,  1, rss_pkg::STAT_NONE, zero_rec);
    add_row(rss_pkg::REQ_FIND_FIRST, ones_rec,  1, rss_pkg::STAT_NONE, zero_rec);
    add_row(rss_pkg::REQ_LOAD,       ones_rec,  1, rss_pkg::STAT_OK,   ones_rec);
    add_row(rss_pkg::REQ_LOAD,       zero_rec,  1, rss_pkg::STAT_OK,   zero_rec);
    add_row(rss_pkg::REQ_LOAD,       john_max,  1, rss_pkg::STAT_OK,   john_max);
    add_row(rss_pkg::REQ_LOAD,       anna_min,  1, rss_pkg::STAT_OK,   anna_min);
    add_row(rss_pkg::REQ_LOAD,       john_dup,  1, rss_pkg::STAT_OK,   john_dup);
    add_row(rss_pkg::REQ_LOAD,       past_nul,  1, rss_pkg::STAT_OK,   past_nul);
    add_row(rss_pkg::REQ_LOAD,       full_len,  1, rss_pkg::STAT_OK,   full_len);
    add_row(rss_pkg::REQ_LOAD,       high_byte, 1, rss_pkg::STAT_OK,   high_byte);
    add_row(rss_pkg::REQ_FIND_SUR,   john_max,  0, rss_pkg::STAT_OK,   zero_rec);
    add_row(rss_pkg::REQ_FIND_FIRST, anna_min,  0, rss_pkg::STAT_OK,   zero_rec);
    add_row(rss_pkg::REQ_FIND_SUR,   near_miss, 1, rss_pkg::STAT_NONE, zero_rec);
    add_row(rss_pkg::REQ_FIND_SUR,   zero_rec,  0, rss_pkg::STAT_OK,   zero_rec);
    add_row(rss_pkg::REQ_FIND_FIRST, near_miss, 1, rss_pkg::STAT_NONE, zero_rec);
    add_row(rss_pkg::REQ_SORT,       zero_rec,  0, rss_pkg::STAT_OK,   zero_rec);
    add_row(rss_pkg::REQ_FIND_SUR,   john_max,  0, rss_pkg::STAT_OK,   zero_rec);
    add_row(rss_pkg::REQ_FIND_FIRST, ones_rec,  0, rss_pkg::STAT_OK,   zero_rec);
    add_row(rss_pkg::REQ_SORT,       ones_rec,  0, rss_pkg::STAT_OK,   zero_rec);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      send_request(directed_rows[k].req, directed_rows[k].data);
      if (directed_rows[k].typed) begin
        void'(expected_replies.pop_back());
        expected_replies.push_back('{directed_rows[k].status, directed_rows[k].rec, 1'b1});
      end
    end
    drain_replies();

    for (int p = 0; p < 4; p++) begin
      gap_pct = gap_tab[p];
      stall_pct = stall_tab[p];
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        // hold the receiver off while requests keep coming
        if (p == 0 && k == 20) hold_request = 1'b1;
        random_request();
      end
      drain_replies();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("name_record_sort_and_search: match");
    end else begin
      $display("name_record_sort_and_search: mismatch");
    end
    $finish;
  end

endmodule
